/* src/brf_pkg.sv */
// Shared types, codes and default sizes for the byte ring FIFO.
// Used by the controller and the top level.
package brf_pkg;

  // Default sizes handed to the top-level parameters
  localparam int DepthDefault    = 256;
  localparam int MaxBurstDefault = 64;

  // Width of the capacity register and of the internal length arithmetic
  localparam int CapW = 9;
  localparam logic [CapW-1:0] CapResetVal = 9'd256;

  // Operation codes carried in the mode field
  localparam logic [2:0] ModeWrite      = 3'd0;
  localparam logic [2:0] ModeForceWrite = 3'd1;
  localparam logic [2:0] ModeRead       = 3'd2;
  localparam logic [2:0] ModePeek       = 3'd3;
  localparam logic [2:0] ModeDiscard    = 3'd4;
  localparam logic [2:0] ModeResetIdx   = 3'd5;

  // Controller states
  typedef enum logic {
    StIdle,
    StStream
  } brf_state_e;

  // One result item as held in the output register
  typedef struct packed {
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       last;
    logic [7:0] done_count;
    logic [7:0] used_after;
    logic [7:0] free_after;
  } brf_result_t;

endpackage

/* src/brf_ifs.sv */
// Valid/ready channel interfaces of the byte ring FIFO: input items,
// result items and the capacity write channel. No dependencies.
interface brf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] write_byte;
  logic [7:0] request_count;

  modport source (output valid, output mode, output write_byte, output request_count,
                  input ready);
  modport sink   (input valid, input mode, input write_byte, input request_count,
                  output ready);
endinterface

interface brf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       byte_valid;
  logic       last;
  logic [7:0] done_count;
  logic [7:0] used_after;
  logic [7:0] free_after;

  modport source (output valid, output read_byte, output byte_valid, output last,
                  output done_count, output used_after, output free_after,
                  input ready);
  modport sink   (input valid, input read_byte, input byte_valid, input last,
                  input done_count, input used_after, input free_after,
                  output ready);
endinterface

interface brf_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

/* src/brf_mem.sv */
// Byte store of the ring: one write port and one read port with registered
// read data. No package dependencies.
module brf_mem #(
  parameter int Depth = 256,
  parameter int AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  // Store a byte on write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Fetch a byte; hold the last fetch while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/brf_ctrl.sv */
// Controller of the byte ring FIFO: indices, capacity register, burst
// sequencer and output register. Depends on brf_pkg and the channel interfaces.
module brf_ctrl #(
  parameter int DEPTH     = brf_pkg::DepthDefault,
  parameter int MAX_BURST = brf_pkg::MaxBurstDefault,
  parameter int IW        = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  brf_in_if.sink         item_i,
  brf_out_if.source      result_o,
  brf_cfg_if.sink        cfg_i,
  output logic           mem_we_o,
  output logic [IW-1:0]  mem_waddr_o,
  output logic [7:0]     mem_wdata_o,
  output logic           mem_re_o,
  output logic [IW-1:0]  mem_raddr_o,
  input  logic [7:0]     mem_rdata_i
);

  import brf_pkg::*;

  localparam int LenMaxInt = (DEPTH < 511) ? DEPTH : 511;
  localparam logic [CapW-1:0] LenMax = CapW'(LenMaxInt);
  localparam logic [CapW-1:0] MaxBurst = CapW'(MAX_BURST);
  localparam int BW = $clog2(MAX_BURST + 1);

  brf_state_e        state_q, state_d;
  logic [CapW-1:0]   cap_q, cap_d;
  logic [IW-1:0]     w_q, w_d, r_q, r_d;
  logic [IW-1:0]     rd_addr_q, rd_addr_d;
  logic [BW-1:0]     remain_q, remain_d;
  logic [7:0]        done_q, done_d, used_q, used_d, free_q, free_d;
  brf_result_t       out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [CapW-1:0]   len, w9, r9, used9, free9, req9, burst_n, disc_n, n_sel;
  logic [CapW:0]     adv_sum;
  logic [IW-1:0]     r_adv, w_inc, r_inc, rd_inc;
  logic              tiny, accept, out_free, is_burst, cfg_write;

  // Step an index by one with wrap at the ring length
  function automatic logic [IW-1:0] wrap_inc(logic [IW-1:0] idx, logic [CapW-1:0] ln);
    logic [CapW:0] s;
    s = (CapW+1)'(idx) + (CapW+1)'(1);
    return (s >= {1'b0, ln}) ? '0 : s[IW-1:0];
  endfunction

  // Ring length and occupancy from the indices
  always_comb begin
    len   = (cap_q > LenMax) ? LenMax : cap_q;
    tiny  = (len < CapW'(2));
    w9    = CapW'(w_q);
    r9    = CapW'(r_q);
    if (tiny) begin
      used9 = '0;
      free9 = '0;
    end else begin
      used9 = (w9 >= r9) ? (w9 - r9) : (len - (r9 - w9));
      free9 = len - CapW'(1) - used9;
    end
    req9    = CapW'(item_i.request_count);
    burst_n = (req9 > MaxBurst) ? MaxBurst : req9;
    burst_n = (burst_n > used9) ? used9 : burst_n;
    disc_n  = (req9 > used9) ? used9 : req9;
    is_burst = (item_i.mode == ModeRead) || (item_i.mode == ModePeek);
    n_sel   = is_burst ? burst_n : disc_n;
    adv_sum = (CapW+1)'(r9) + (CapW+1)'(n_sel);
    r_adv   = (adv_sum >= {1'b0, len}) ? IW'(adv_sum - {1'b0, len}) : IW'(adv_sum);
    w_inc   = wrap_inc(w_q, len);
    r_inc   = wrap_inc(r_q, len);
    rd_inc  = wrap_inc(rd_addr_q, len);
  end

  // Handshakes: a capacity write waits for the burst to finish and blocks items
  assign out_free     = !out_valid_q || result_o.ready;
  assign cfg_i.ready  = (state_q == StIdle);
  assign cfg_write    = cfg_i.valid && cfg_i.ready;
  assign item_i.ready = (state_q == StIdle) && out_free && !cfg_i.valid;
  assign accept       = item_i.valid && item_i.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && is_burst && (burst_n != '0)) begin
          state_d = StStream;
        end
      end
      StStream: begin
        if (out_free && (remain_q == BW'(1))) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath, memory access and result loading
  always_comb begin
    cap_d       = cap_q;
    w_d         = w_q;
    r_d         = r_q;
    rd_addr_d   = rd_addr_q;
    remain_d    = remain_q;
    done_d      = done_q;
    used_d      = used_q;
    free_d      = free_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !result_o.ready;
    mem_we_o    = 1'b0;
    mem_waddr_o = w_q;
    mem_wdata_o = item_i.write_byte;
    mem_re_o    = 1'b0;
    mem_raddr_o = r_q;

    if (cfg_write) begin
      // Capacity write empties the ring
      cap_d = cfg_i.capacity;
      w_d   = '0;
      r_d   = '0;
    end else if (state_q == StIdle) begin
      if (accept) begin
        out_d.read_byte  = '0;
        out_d.byte_valid = 1'b0;
        out_d.last       = 1'b1;
        out_d.done_count = '0;
        out_d.used_after = used9[7:0];
        out_d.free_after = free9[7:0];
        out_valid_d      = 1'b1;
        case (item_i.mode)
          ModeWrite: begin
            if (free9 != '0) begin
              mem_we_o         = 1'b1;
              w_d              = w_inc;
              out_d.done_count = 8'd1;
              out_d.used_after = 8'(used9 + CapW'(1));
              out_d.free_after = 8'(free9 - CapW'(1));
            end
          end
          ModeForceWrite: begin
            if (!tiny) begin
              mem_we_o         = 1'b1;
              w_d              = w_inc;
              out_d.done_count = 8'd1;
              if (free9 == '0) begin
                // Drop the oldest byte to make room
                r_d = r_inc;
              end else begin
                out_d.used_after = 8'(used9 + CapW'(1));
                out_d.free_after = 8'(free9 - CapW'(1));
              end
            end
          end
          ModeRead, ModePeek: begin
            if (burst_n != '0) begin
              // Start the burst: fetch the oldest byte, report later
              out_valid_d = out_valid_q && !result_o.ready;
              out_d       = out_q;
              mem_re_o    = 1'b1;
              mem_raddr_o = r_q;
              rd_addr_d   = r_inc;
              remain_d    = burst_n[BW-1:0];
              done_d      = burst_n[7:0];
              used_d      = used9[7:0];
              free_d      = free9[7:0];
              if (item_i.mode == ModeRead) begin
                // Read removes the bytes; peek leaves the counts alone
                r_d    = r_adv;
                used_d = 8'(used9 - burst_n);
                free_d = 8'(free9 + burst_n);
              end
            end
          end
          ModeDiscard: begin
            r_d              = r_adv;
            out_d.done_count = disc_n[7:0];
            out_d.used_after = 8'(used9 - disc_n);
            out_d.free_after = 8'(free9 + disc_n);
          end
          ModeResetIdx: begin
            w_d              = '0;
            r_d              = '0;
            out_d.used_after = '0;
            out_d.free_after = tiny ? 8'd0 : 8'(len - CapW'(1));
          end
          default: begin
          end
        endcase
      end
    end else begin
      // Stream: hand the fetched byte over and fetch the next one
      if (out_free) begin
        out_d.read_byte  = mem_rdata_i;
        out_d.byte_valid = 1'b1;
        out_d.last       = (remain_q == BW'(1));
        out_d.done_count = done_q;
        out_d.used_after = used_q;
        out_d.free_after = free_q;
        out_valid_d      = 1'b1;
        remain_d         = remain_q - BW'(1);
        if (remain_q != BW'(1)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = rd_addr_q;
          rd_addr_d   = rd_inc;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cap_q       <= CapResetVal;
      w_q         <= '0;
      r_q         <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      w_q         <= w_d;
      r_q         <= r_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    done_q    <= done_d;
    used_q    <= used_d;
    free_q    <= free_d;
    out_q     <= out_d;
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.read_byte  = out_q.read_byte;
  assign result_o.byte_valid = out_q.byte_valid;
  assign result_o.last       = out_q.last;
  assign result_o.done_count = out_q.done_count;
  assign result_o.used_after = out_q.used_after;
  assign result_o.free_after = out_q.free_after;

endmodule

/* src/byte_ring_fifo_with_overwrite.sv */
// Byte ring FIFO with one slot left empty and an overwriting force write.
// Holds at most capacity-1 bytes (capacity clipped to DEPTH and to 511, values
// below 2 give no room). Writes, force writes, discards, index resets and unused
// modes are accepted back to back while the sink takes results and no capacity
// write is pending. A read or peek first fetches the oldest byte from the store's
// registered read port, then delivers one byte per cycle while the sink takes
// them; no new item is taken until its last byte is in the output register. A
// capacity write empties the ring. There is no clearing pass after reset. Depends
// on brf_pkg, the channel interfaces, brf_ctrl and brf_mem.
module byte_ring_fifo_with_overwrite #(
  parameter int DEPTH     = brf_pkg::DepthDefault,
  parameter int MAX_BURST = brf_pkg::MaxBurstDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  brf_in_if.sink     item_i,
  brf_out_if.source  result_o,
  brf_cfg_if.sink    cfg_i
);

  import brf_pkg::*;

  localparam int LenMaxInt = (DEPTH < 511) ? DEPTH : 511;
  localparam int IW = $clog2(LenMaxInt);

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  // Sequencer and index logic
  brf_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST),
    .IW        (IW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .result_o    (result_o),
    .cfg_i       (cfg_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Ring byte store
  brf_mem #(
    .Depth (LenMaxInt),
    .AddrW (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

/* src/brf_checker.sv */
// Port-level checks of the byte ring FIFO and the bind that attaches them
// to the top level. Depends on byte_ring_fifo_with_overwrite.
module brf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_byte_valid_i,
  input logic       out_last_i,
  input logic [7:0] out_done_i,
  input logic [7:0] out_used_i,
  input logic [7:0] out_free_i
);

  // Stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(out_last_i) && $stable(out_used_i) && $stable(out_free_i))
    else $error("stalled result changed");

  // A result without a byte always closes its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_byte_valid_i |-> out_last_i)
    else $error("empty result not marked last");

  // A delivered byte belongs to a burst of nonzero size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_byte_valid_i |-> out_done_i != 8'd0)
    else $error("byte delivered with zero count");

  // No item is taken while a burst is still being delivered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !(in_valid_i && in_ready_i))
    else $error("item accepted mid-burst");

endmodule

bind byte_ring_fifo_with_overwrite brf_checker u_brf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (item_i.valid),
  .in_ready_i       (item_i.ready),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .out_byte_i       (result_o.read_byte),
  .out_byte_valid_i (result_o.byte_valid),
  .out_last_i       (result_o.last),
  .out_done_i       (result_o.done_count),
  .out_used_i       (result_o.used_after),
  .out_free_i       (result_o.free_after)
);
